// ===== rtl/bldg_pkg.sv =====
package bldg_pkg;

	// full-scale duty and number of speed levels
	localparam int DUTY_FULL_SCALE = 1023;
	localparam int SPEED_LEVELS    = 5;
	localparam int DEFAULT_SPEED   = 3;

	// field widths
	localparam int DUTY_W  = 10;
	localparam int PCT_W   = 7;
	localparam int SPEED_W = 3;
	localparam int CNT_W   = 5;
	localparam int STEP_W  = 6;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 7;

	// internal duty level width follows the full scale
	localparam int LVL_W = $clog2(DUTY_FULL_SCALE + 1);

	// percent scaling: x / 100 as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^23
	localparam int          PCT_MAX     = 100;
	localparam int          RECIP_SHIFT = 32;
	localparam longint      RECIP       = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
	localparam int          RECIP_W     = 26;
	localparam int          SCALED_W    = PCT_W + $clog2(DUTY_FULL_SCALE + 1);
	localparam int          PROD_W      = SCALED_W + RECIP_W;

	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [PCT_W-1:0]   pct_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [DUTY_W-1:0]  duty_t;

	// register indexes
	localparam idx_t REG_POWER  = 2'd0;
	localparam idx_t REG_MODE   = 2'd1;
	localparam idx_t REG_BRIGHT = 2'd2;
	localparam idx_t REG_SPEED  = 2'd3;

	// duty amount per breathing step, levels above the table use the last entry
	function automatic step_t step_size(input speed_t level);
		step_t s;
		unique case (level)
			3'd0, 3'd1: s = 6'd2;
			3'd2:       s = 6'd5;
			3'd3:       s = 6'd10;
			3'd4:       s = 6'd20;
			default:    s = 6'd40;
		endcase
		return s;
	endfunction

	// milliseconds between breathing steps
	function automatic cnt_t step_ms(input speed_t level);
		cnt_t c;
		unique case (level)
			3'd0, 3'd1: c = 5'd30;
			3'd2:       c = 5'd20;
			3'd3:       c = 5'd15;
			3'd4:       c = 5'd10;
			default:    c = 5'd8;
		endcase
		return c;
	endfunction

	// percent times full scale over 100, truncated
	function automatic lvl_t target_duty(input pct_t pct);
		logic [SCALED_W-1:0] scaled;
		logic [PROD_W-1:0]   prod;
		scaled = SCALED_W'(pct) * SCALED_W'(DUTY_FULL_SCALE);
		prod   = PROD_W'(scaled) * PROD_W'(RECIP);
		return LVL_W'(prod >> RECIP_SHIFT);
	endfunction

endpackage

// ===== rtl/breathing_led_duty_generator_core.sv =====
// channel | handshake                  | payload
// item    | item_valid / item_stall    | tick
// result  | result_valid / result_stall| duty, rising, stepped
// config  | wr_en                      | wr_index, wr_data
//
// one item every clock unless the result stalls; items pass the input register, then the result register
// the step update is a single add/subtract and compare against the stored limit
// the limit multiply runs only on a brightness write, straight into its register
// arst_n low: power on, breathing, 100 percent, speed 3, duty 0 rising, count 15
// a stalled result holds the result register; the input register then stalls
module breathing_led_duty_generator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    tick,
	output logic                    result_valid,
	input  logic                    result_stall,
	output bldg_pkg::duty_t         duty,
	output logic                    rising,
	output logic                    stepped,
	input  logic                    wr_en,
	input  bldg_pkg::idx_t          wr_index,
	input  bldg_pkg::data_t         wr_data
);
	import bldg_pkg::*;

	// configuration registers
	logic   power_q;
	logic   breath_q;
	pct_t   bright_q;
	speed_t speed_q;
	lvl_t   target_q;

	// breathing state
	lvl_t   duty_level_q;
	logic   dir_up_q;
	cnt_t   cnt_q;

	// input stage
	logic   valid_s1;
	logic   tick_s1;
	logic   adv;

	// next state for the item in the input stage
	logic                 run;
	logic                 step_fire;
	step_t                step;
	logic [LVL_W:0]       moved;
	lvl_t                 duty_nx;
	logic                 dir_nx;
	cnt_t                 cnt_nx;

	// saturated and clamped write values
	pct_t   bright_wr;
	speed_t speed_wr;
	lvl_t   target_wr;

	// handshake: the input stage moves on when the result register is free
	assign adv        = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			tick_s1 <= tick;
		end
	end

	// breathing step
	always_comb begin
		run       = tick_s1 && power_q && breath_q;
		step_fire = run && (cnt_q <= CNT_W'(1));
		step      = step_size(speed_q);
		if (dir_up_q) begin
			moved = (LVL_W + 1)'(duty_level_q) + (LVL_W + 1)'(step);
		end else if (duty_level_q > LVL_W'(step)) begin
			moved = (LVL_W + 1)'(duty_level_q) - (LVL_W + 1)'(step);
		end else begin
			moved = '0;
		end
		duty_nx = duty_level_q;
		dir_nx  = dir_up_q;
		cnt_nx  = cnt_q;
		if (step_fire) begin
			cnt_nx = step_ms(speed_q);
			priority if (moved >= (LVL_W + 1)'(target_q)) begin
				duty_nx = target_q;
				dir_nx  = 1'b0;
			end else if (moved == '0) begin
				duty_nx = '0;
				dir_nx  = 1'b1;
			end else begin
				duty_nx = LVL_W'(moved);
			end
		end else if (run) begin
			cnt_nx = cnt_q - CNT_W'(1);
		end
	end

	// write value conditioning
	always_comb begin
		bright_wr = (wr_data > DATA_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(wr_data);
		speed_wr  = SPEED_W'(wr_data);
		if (speed_wr == '0) begin
			speed_wr = SPEED_W'(1);
		end else if (32'(speed_wr) > SPEED_LEVELS) begin
			speed_wr = SPEED_W'(SPEED_LEVELS);
		end
		target_wr = target_duty(bright_wr);
	end

	// configuration and state; the user writes only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q      <= 1'b1;
			breath_q     <= 1'b1;
			bright_q     <= PCT_W'(PCT_MAX);
			speed_q      <= SPEED_W'(DEFAULT_SPEED);
			target_q     <= LVL_W'(DUTY_FULL_SCALE);
			duty_level_q <= '0;
			dir_up_q     <= 1'b1;
			cnt_q        <= step_ms(SPEED_W'(DEFAULT_SPEED));
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POWER: begin
					power_q <= wr_data[0];
					if (wr_data[0]) begin
						if (!breath_q) begin
							duty_level_q <= target_q;
						end else begin
							duty_level_q <= '0;
							dir_up_q     <= 1'b1;
							cnt_q        <= step_ms(speed_q);
						end
					end
				end
				REG_MODE: begin
					breath_q <= wr_data[0];
					if (!wr_data[0]) begin
						duty_level_q <= target_q;
					end else if (power_q) begin
						cnt_q <= step_ms(speed_q);
					end
				end
				REG_BRIGHT: begin
					bright_q <= bright_wr;
					target_q <= target_wr;
					if (!breath_q) begin
						duty_level_q <= target_wr;
					end
				end
				REG_SPEED: begin
					speed_q <= speed_wr;
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			duty_level_q <= duty_nx;
			dir_up_q     <= dir_nx;
			cnt_q        <= cnt_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty    <= power_q ? DUTY_W'(duty_nx) : '0;
			rising  <= dir_nx;
			stepped <= step_fire;
		end
	end

	// the countdown never rests at zero
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0)
		else $error("interval count reached zero");

	// the limit stays within full scale and matches the stored percent
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		(target_q <= LVL_W'(DUTY_FULL_SCALE)) && (target_q == target_duty(bright_q)))
		else $error("duty limit out of step with brightness");

	// input stalls only while an item waits behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a held result");

	// an item transfer without a step leaves the duty level alone
	a_step_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !wr_en && !step_fire) |=> $stable(duty_level_q))
		else $error("duty level moved without a step");

	// brightness stays saturated at 100 percent
	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		bright_q <= PCT_W'(PCT_MAX))
		else $error("brightness above 100 percent");

endmodule

// ===== sim/bldg_duty_checker.sv =====
`timescale 1ns / 1ps

// watches the item, result and register-write ports and predicts every result
module bldg_duty_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  logic             tick,
	input  logic             result_valid,
	input  logic             result_stall,
	input  bldg_pkg::duty_t  duty,
	input  logic             rising,
	input  logic             stepped,
	input  logic             wr_en,
	input  bldg_pkg::idx_t   wr_index,
	input  bldg_pkg::data_t  wr_data,
	output int               mismatches,
	output int               waiting
);
	import bldg_pkg::*;

	typedef struct packed {
		duty_t duty;
		logic  rising;
		logic  stepped;
	} duty_report_t;

	// per-speed step amount and milliseconds between steps, speeds 1..5
	localparam int STEP_AMOUNT [5] = '{2, 5, 10, 20, 40};
	localparam int INTERVAL_MS [5] = '{30, 20, 15, 10, 8};

	// mirrored registers
	logic pwr;
	logic breathe;
	int   pct;
	int   speed;

	// mirrored breathing state
	int   level;
	logic up;
	int   countdown;

	duty_report_t duty_reports_q[$];
	duty_report_t want;

	initial mismatches = 0;

	function automatic int speed_row(input int s);
		int l;
		l = s;
		if (l < 1) l = 1;
		if (l > 5) l = 5;
		return l - 1;
	endfunction

	function automatic int peak_duty();
		return pct * DUTY_FULL_SCALE / 100;
	endfunction

	function automatic void reset_model();
		pwr       = 1'b1;
		breathe   = 1'b1;
		pct       = 100;
		speed     = DEFAULT_SPEED;
		level     = 0;
		up        = 1'b1;
		countdown = INTERVAL_MS[speed_row(DEFAULT_SPEED)];
	endfunction

	// register write side effects
	function automatic void apply_write(input idx_t idx, input data_t d);
		int s;
		if (idx == REG_POWER) begin
			pwr = d[0];
			if (pwr) begin
				if (!breathe) begin
					level = peak_duty();
				end else begin
					level     = 0;
					up        = 1'b1;
					countdown = INTERVAL_MS[speed_row(speed)];
				end
			end
		end else if (idx == REG_MODE) begin
			breathe = d[0];
			if (!breathe) level = peak_duty();
			else if (pwr) countdown = INTERVAL_MS[speed_row(speed)];
		end else if (idx == REG_BRIGHT) begin
			pct = (int'(d) > 100) ? 100 : int'(d);
			if (!breathe) level = peak_duty();
		end else if (idx == REG_SPEED) begin
			s = int'(d[2:0]);
			if (s < 1) s = 1;
			if (s > SPEED_LEVELS) s = SPEED_LEVELS;
			speed = s;
		end
	endfunction

	// one millisecond item: advance the triangle and report
	function automatic duty_report_t advance(input logic t);
		duty_report_t r;
		int amount;
		int limit;
		logic moved;
		moved = 1'b0;
		if (t && pwr && breathe) begin
			if (countdown <= 1) begin
				amount = STEP_AMOUNT[speed_row(speed)];
				limit  = peak_duty();
				if (up) level = level + amount;
				else level = (level > amount) ? level - amount : 0;
				// top end is checked first, so a zero limit stays falling
				if (level >= limit) begin
					level = limit;
					up    = 1'b0;
				end else if (level == 0) begin
					up = 1'b1;
				end
				countdown = INTERVAL_MS[speed_row(speed)];
				moved     = 1'b1;
			end else begin
				countdown = countdown - 1;
			end
		end
		r.duty    = duty_t'(pwr ? level : 0);
		r.rising  = up;
		r.stepped = moved;
		return r;
	endfunction

	// predict on each item transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			duty_reports_q.delete();
			waiting <= 0;
		end else begin
			if (wr_en) apply_write(wr_index, wr_data);
			if (item_valid && !item_stall) duty_reports_q.push_back(advance(tick));
			if (result_valid && !result_stall) begin
				if (duty_reports_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none expected: duty %0d rising %0b stepped %0b",
							$time, duty, rising, stepped);
					mismatches = mismatches + 1;
				end else begin
					want = duty_reports_q.pop_front();
					if (duty !== want.duty || rising !== want.rising ||
							stepped !== want.stepped) begin
						if (mismatches < 10)
							$display("%0t: expected duty %0d rising %0b stepped %0b, got duty %0d rising %0b stepped %0b",
								$time, want.duty, want.rising, want.stepped,
								duty, rising, stepped);
						mismatches = mismatches + 1;
					end
				end
			end
			waiting <= duty_reports_q.size();
		end
	end

endmodule

// ===== sim/tb_breathing_led_duty_generator_core.sv =====
`timescale 1ns / 1ps

module tb_breathing_led_duty_generator_core;
	import bldg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 75;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    tick         = 1'b0;
	logic    result_stall = 1'b0;
	logic    wr_en        = 1'b0;
	idx_t    wr_index     = REG_POWER;
	data_t   wr_data      = '0;
	logic    item_stall;
	logic    result_valid;
	duty_t   duty;
	logic    rising;
	logic    stepped;

	int mismatches;
	int waiting;
	int tx_idle_pct = 22;
	int rx_idle_pct = 46;
	int hold_reqs   = 0;
	int hold_seen   = 0;
	int hold_left   = 0;
	int cycles      = 0;

	breathing_led_duty_generator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.duty         (duty),
		.rising       (rising),
		.stepped      (stepped),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	bldg_duty_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.duty         (duty),
		.rising       (rising),
		.stepped      (stepped),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.mismatches   (mismatches),
		.waiting      (waiting)
	);

	always #10 clk = ~clk;

	// receiver stalls: random, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_reqs != hold_seen) begin
			result_stall <= 1'b1;
			hold_seen    <= hold_seen + 1;
			hold_left    <= HOLD_CYCLES;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_breathing_led_duty_generator_core failed");
			$finish;
		end
	end

	// offer one millisecond item, with a random gap first
	task automatic send_tick(input logic t);
		if ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid <= 1'b1;
		tick       <= t;
		do @(posedge clk); while (item_stall);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// registers change only with the block idle
	task automatic write_reg(input idx_t idx, input int value);
		settle();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data_t'(value);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		int   phase;
		int   n;
		int   k;
		int   first;
		int   pick;
		int   value;
		idx_t sel;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state reported without a tick
		send_tick(1'b0);

		// fastest speed (clamped from 7), limit 30: top reversal, clamp at zero, bottom reversal
		write_reg(REG_SPEED, 7);
		write_reg(REG_BRIGHT, 3);
		write_reg(REG_POWER, 1);
		repeat (16) send_tick(1'b1);

		// zero limit keeps the duty at zero, falling
		write_reg(REG_BRIGHT, 0);
		write_reg(REG_POWER, 1);
		repeat (8) send_tick(1'b1);

		// steady mode, slowest speed clamped from 0, brightness saturating
		write_reg(REG_SPEED, 0);
		write_reg(REG_MODE, 0);
		send_tick(1'b1);
		write_reg(REG_BRIGHT, 127);
		send_tick(1'b0);

		// power off reports zero, breathing entered while off, then power back on
		write_reg(REG_POWER, 0);
		send_tick(1'b1);
		write_reg(REG_MODE, 1);
		send_tick(1'b1);
		write_reg(REG_POWER, 1);
		send_tick(1'b1);

		// random phases: fresh settings, then mostly ticks
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == PHASES / 3) begin
				tx_idle_pct = 46;
				rx_idle_pct <= 22;
			end else if (phase == 2 * PHASES / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			first = $urandom_range(3);
			for (k = 0; k < 4; k++) begin
				sel = idx_t'((first + k) % 4);
				if ($urandom_range(99) < 60) begin
					if (sel == REG_POWER) begin
						value = ($urandom_range(99) < 85);
					end else if (sel == REG_MODE) begin
						value = ($urandom_range(99) < 75);
					end else if (sel == REG_BRIGHT) begin
						// small limits reach both ends of the triangle quickly
						pick = $urandom_range(9);
						if (pick < 5) value = $urandom_range(0, 20);
						else if (pick < 8) value = $urandom_range(0, 127);
						else value = $urandom_range(90, 127);
					end else begin
						value = $urandom_range(0, 7);
					end
					write_reg(sel, value);
				end
			end
			if (phase == 2 || phase == 9) hold_reqs <= hold_reqs + 1;
			for (n = 0; n < PHASE_ITEMS; n++) send_tick($urandom_range(99) < 85);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("tb_breathing_led_duty_generator_core passed");
		else
			$display("tb_breathing_led_duty_generator_core failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bldg_pkg.sv
rtl/breathing_led_duty_generator_core.sv
sim/bldg_duty_checker.sv
sim/tb_breathing_led_duty_generator_core.sv
